// ----- rtl/sdl_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sdl_pkg
// Shared types, register indexes and helpers for the link force pipeline.
// ---------------------------------------------------------------------------
package sdl_pkg;

	localparam int DIMS       = 3;
	localparam int SQRT_STEPS = 32;
	localparam int DIV_STEPS  = 31;

	localparam logic [63:0] LEN_EPS_SQ = 64'd4295;

	typedef logic [2:0] reg_idx_t;
	localparam reg_idx_t REG_REST_X  = 3'd0;
	localparam reg_idx_t REG_REST_Y  = 3'd1;
	localparam reg_idx_t REG_REST_Z  = 3'd2;
	localparam reg_idx_t REG_KS      = 3'd3;
	localparam reg_idx_t REG_KD      = 3'd4;

	typedef logic [2:0][31:0] vec3_t;

	// side data travelling with the two roots
	typedef struct packed {
		vec3_t d;
		vec3_t v;
		logic  dot_neg;
		logic  dzero;
		logic  damp_en;
	} link_sb_t;

	// side data travelling with the divisions
	typedef struct packed {
		link_sb_t    sb;
		logic [31:0] len;
		logic [31:0] len0;
	} div_sb_t;

	function automatic logic [31:0] sat32(input logic signed [65:0] x);
		logic [31:0] r;
		if (x > 66'sd2147483647)
			r = 32'h7fff_ffff;
		else if (x < -66'sd2147483648)
			r = 32'h8000_0000;
		else
			r = x[31:0];
		return r;
	endfunction

endpackage

// ----- rtl/spring_damper_link_force_top.sv -----
`timescale 1ns / 1ps
// Pipeline: front, root, divide and back sections, from input beat to output beat.
// Throughput: one link per cycle; the whole pipe advances together and holds when
// the output register is full and not taken.
// Reset: arst_n clears all valid bits and the config registers (rest vector, ks, kd to 0).
// ---------------------------------------------------------------------------
// spring_damper_link_force_top
// Spring-damper force along a 3-D link, Q16.16, saturating.
// ---------------------------------------------------------------------------
module spring_damper_link_force_top (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   wr_en,
	input  sdl_pkg::reg_idx_t      wr_index,
	input  logic [31:0]            wr_data,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic signed [31:0]     first_pos_x,
	input  logic signed [31:0]     first_pos_y,
	input  logic signed [31:0]     first_pos_z,
	input  logic signed [31:0]     second_pos_x,
	input  logic signed [31:0]     second_pos_y,
	input  logic signed [31:0]     second_pos_z,
	input  logic signed [31:0]     first_vel_x,
	input  logic signed [31:0]     first_vel_y,
	input  logic signed [31:0]     first_vel_z,
	input  logic signed [31:0]     second_vel_x,
	input  logic signed [31:0]     second_vel_y,
	input  logic signed [31:0]     second_vel_z,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic signed [31:0]     force_first_x,
	output logic signed [31:0]     force_first_y,
	output logic signed [31:0]     force_first_z,
	output logic signed [31:0]     force_second_x,
	output logic signed [31:0]     force_second_y,
	output logic signed [31:0]     force_second_z
);
	import sdl_pkg::*;

	vec3_t       rest_q;
	logic [30:0] ks_q, kd_q;

	logic        en;
	logic        f_vld, s_vld, d_vld;
	logic [63:0] dsq, rsq;
	link_sb_t    f_sb;
	div_sb_t     s_sb, d_sb;
	vec3_t       unit, f_first, f_second;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rest_q <= '0;
			ks_q   <= '0;
			kd_q   <= '0;
		end else if (wr_en) begin
			case (wr_index)
				REG_REST_X: rest_q[0] <= wr_data;
				REG_REST_Y: rest_q[1] <= wr_data;
				REG_REST_Z: rest_q[2] <= wr_data;
				REG_KS:     ks_q      <= wr_data[30:0];
				REG_KD:     kd_q      <= wr_data[30:0];
				default: ;
			endcase
		end
	end

	// whole pipe moves unless the output beat is stuck
	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	sdl_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.vld_in  (in_valid),
		.pos_a   ({first_pos_z, first_pos_y, first_pos_x}),
		.pos_b   ({second_pos_z, second_pos_y, second_pos_x}),
		.vel_a   ({first_vel_z, first_vel_y, first_vel_x}),
		.vel_b   ({second_vel_z, second_vel_y, second_vel_x}),
		.rest    (rest_q),
		.vld_out (f_vld),
		.dsq     (dsq),
		.rsq     (rsq),
		.sb      (f_sb)
	);

	sdl_sqrt u_sqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.vld_in  (f_vld),
		.dsq     (dsq),
		.rsq     (rsq),
		.sb_in   (f_sb),
		.vld_out (s_vld),
		.sb_out  (s_sb)
	);

	sdl_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.vld_in  (s_vld),
		.sb_in   (s_sb),
		.vld_out (d_vld),
		.sb_out  (d_sb),
		.unit    (unit)
	);

	sdl_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.vld_in   (d_vld),
		.sb_in    (d_sb),
		.unit     (unit),
		.ks       (ks_q),
		.kd       (kd_q),
		.vld_out  (out_valid),
		.f_first  (f_first),
		.f_second (f_second)
	);

	assign force_first_x  = f_first[0];
	assign force_first_y  = f_first[1];
	assign force_first_z  = f_first[2];
	assign force_second_x = f_second[0];
	assign force_second_y = f_second[1];
	assign force_second_z = f_second[2];

endmodule

// ----- rtl/sdl_front.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sdl_front
// Differences, squares and sums: three stages ahead of the root pipes.
// ---------------------------------------------------------------------------
module sdl_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             vld_in,
	input  sdl_pkg::vec3_t   pos_a,
	input  sdl_pkg::vec3_t   pos_b,
	input  sdl_pkg::vec3_t   vel_a,
	input  sdl_pkg::vec3_t   vel_b,
	input  sdl_pkg::vec3_t   rest,
	output logic             vld_out,
	output logic [63:0]      dsq,
	output logic [63:0]      rsq,
	output sdl_pkg::link_sb_t sb
);
	import sdl_pkg::*;

	logic signed [32:0] dd [3];
	logic signed [32:0] vd [3];

	vec3_t d_s1, v_s1, d_s2, v_s2;
	logic signed [63:0] dd_s2 [3];
	logic signed [63:0] vv_s2 [3];
	logic signed [63:0] rr_s2 [3];
	logic signed [63:0] dr_s2 [3];
	logic vld_s1, vld_s2, vld_s3;

	logic [63:0] dsum, vsum, rsum;
	logic signed [65:0] dot;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			dd[k] = $signed({pos_b[k][31], pos_b[k]}) - $signed({pos_a[k][31], pos_a[k]});
			vd[k] = $signed({vel_b[k][31], vel_b[k]}) - $signed({vel_a[k][31], vel_a[k]});
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				if (k < DIMS) begin
					d_s1[k] <= sat32(66'(dd[k]));
					v_s1[k] <= sat32(66'(vd[k]));
				end else begin
					d_s1[k] <= '0;
					v_s1[k] <= '0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_s2 <= d_s1;
			v_s2 <= v_s1;
			for (int k = 0; k < 3; k++) begin
				dd_s2[k] <= $signed(d_s1[k]) * $signed(d_s1[k]);
				vv_s2[k] <= $signed(v_s1[k]) * $signed(v_s1[k]);
				rr_s2[k] <= (k < DIMS) ? $signed(rest[k]) * $signed(rest[k]) : 64'sd0;
				dr_s2[k] <= $signed(d_s1[k]) * $signed(rest[k]);
			end
		end
	end

	always_comb begin
		dsum = dd_s2[0] + dd_s2[1] + dd_s2[2];
		vsum = vv_s2[0] + vv_s2[1] + vv_s2[2];
		rsum = rr_s2[0] + rr_s2[1] + rr_s2[2];
		dot  = 66'(dr_s2[0]) + 66'(dr_s2[1]) + 66'(dr_s2[2]);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dsq        <= dsum;
			rsq        <= rsum;
			sb.d       <= d_s2;
			sb.v       <= v_s2;
			sb.dot_neg <= dot < 0;
			sb.dzero   <= dsum == '0;
			sb.damp_en <= (vsum >= LEN_EPS_SQ) && (dsum >= LEN_EPS_SQ);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_in;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	assign vld_out = vld_s3;

endmodule

// ----- rtl/sdl_sqrt.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sdl_sqrt
// Two 64-bit integer square roots side by side, one result bit per stage.
// ---------------------------------------------------------------------------
module sdl_sqrt (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              vld_in,
	input  logic [63:0]       dsq,
	input  logic [63:0]       rsq,
	input  sdl_pkg::link_sb_t sb_in,
	output logic              vld_out,
	output sdl_pkg::div_sb_t  sb_out
);
	import sdl_pkg::*;

	logic [63:0] na_s [SQRT_STEPS+1];
	logic [63:0] ra_s [SQRT_STEPS+1];
	logic [63:0] nb_s [SQRT_STEPS+1];
	logic [63:0] rb_s [SQRT_STEPS+1];
	link_sb_t    sb_s [SQRT_STEPS+1];
	logic        vld_s [SQRT_STEPS+1];

	assign na_s[0]  = dsq;
	assign ra_s[0]  = '0;
	assign nb_s[0]  = rsq;
	assign rb_s[0]  = '0;
	assign sb_s[0]  = sb_in;
	assign vld_s[0] = vld_in;

	for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
		localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
		logic [64:0] sum_a, sum_b;
		logic        take_a, take_b;

		always_comb begin
			sum_a  = {1'b0, ra_s[k]} + {1'b0, BIT};
			sum_b  = {1'b0, rb_s[k]} + {1'b0, BIT};
			take_a = {1'b0, na_s[k]} >= sum_a;
			take_b = {1'b0, nb_s[k]} >= sum_b;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				na_s[k+1] <= take_a ? na_s[k] - sum_a[63:0] : na_s[k];
				ra_s[k+1] <= take_a ? (ra_s[k] >> 1) + BIT : ra_s[k] >> 1;
				nb_s[k+1] <= take_b ? nb_s[k] - sum_b[63:0] : nb_s[k];
				rb_s[k+1] <= take_b ? (rb_s[k] >> 1) + BIT : rb_s[k] >> 1;
				sb_s[k+1] <= sb_s[k];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_s[k];
			end
		end
	end

	assign vld_out     = vld_s[SQRT_STEPS];
	assign sb_out.sb   = sb_s[SQRT_STEPS];
	assign sb_out.len  = ra_s[SQRT_STEPS][31:0];
	assign sb_out.len0 = rb_s[SQRT_STEPS][31:0];

endmodule

// ----- rtl/sdl_div.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sdl_div
// Unit vector in Q2.30: |d| * 2^30 / L for each axis, restoring division,
// one quotient bit per stage.
// ---------------------------------------------------------------------------
module sdl_div (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             vld_in,
	input  sdl_pkg::div_sb_t sb_in,
	output logic             vld_out,
	output sdl_pkg::div_sb_t sb_out,
	output sdl_pkg::vec3_t   unit
);
	import sdl_pkg::*;

	logic [31:0] rem_s [DIV_STEPS+1][3];
	logic [30:0] quo_s [DIV_STEPS+1][3];
	div_sb_t     sb_s  [DIV_STEPS+1];
	logic        vld_s [DIV_STEPS+1];
	logic [31:0] mag [3];

	// quotient never exceeds 2^30, so the top of the dividend starts as |d| >> 1
	always_comb begin
		for (int a = 0; a < 3; a++) begin
			mag[a]      = sb_in.sb.d[a][31] ? 32'(-sb_in.sb.d[a]) : sb_in.sb.d[a];
			rem_s[0][a] = {1'b0, mag[a][31:1]};
			quo_s[0][a] = '0;
		end
	end

	assign sb_s[0]  = sb_in;
	assign vld_s[0] = vld_in;

	for (genvar j = 0; j < DIV_STEPS; j++) begin : g_step
		logic [32:0] trial [3];
		logic        ge [3];
		logic        lsb [3];

		always_comb begin
			for (int a = 0; a < 3; a++) begin
				lsb[a]   = (j == 0) ? mag[a][0] : 1'b0;
				trial[a] = {rem_s[j][a], lsb[a]};
				ge[a]    = trial[a] >= {1'b0, sb_s[j].len};
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				for (int a = 0; a < 3; a++) begin
					rem_s[j+1][a] <= ge[a] ? 32'(trial[a] - {1'b0, sb_s[j].len})
						: trial[a][31:0];
					quo_s[j+1][a] <= {quo_s[j][a][29:0], ge[a]};
				end
				sb_s[j+1] <= sb_s[j];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[j+1] <= 1'b0;
			end else if (en) begin
				vld_s[j+1] <= vld_s[j];
			end
		end
	end

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			unit[a] = sb_s[DIV_STEPS].sb.d[a][31] ? 32'(-{1'b0, quo_s[DIV_STEPS][a]})
				: {1'b0, quo_s[DIV_STEPS][a]};
		end
	end

	assign vld_out = vld_s[DIV_STEPS];
	assign sb_out  = sb_s[DIV_STEPS];

endmodule

// ----- rtl/sdl_back.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sdl_back
// Extension, spring and damping terms, total force and the output register.
// ---------------------------------------------------------------------------
module sdl_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             vld_in,
	input  sdl_pkg::div_sb_t sb_in,
	input  sdl_pkg::vec3_t   unit,
	input  logic [30:0]      ks,
	input  logic [30:0]      kd,
	output logic             vld_out,
	output sdl_pkg::vec3_t   f_first,
	output sdl_pkg::vec3_t   f_second
);
	import sdl_pkg::*;

	logic signed [33:0] ext_w;
	logic signed [65:0] vr_w;
	logic signed [65:0] tot_w;

	// B1
	logic [31:0] ext_s1;
	logic signed [63:0] pv_s1 [3];
	vec3_t u_s1;
	logic dz_s1, de_s1;
	// B2
	logic signed [63:0] sp_s2;
	logic [31:0] vr_s2;
	vec3_t u_s2;
	logic dz_s2;
	// B3
	logic signed [47:0] s_s3;
	logic signed [63:0] dp_s3;
	vec3_t u_s3;
	logic dz_s3;
	// B4
	logic [31:0] t_s4;
	vec3_t u_s4;
	logic dz_s4;
	// B5
	logic signed [63:0] fp_s5 [3];
	logic dz_s5;

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;
	logic [31:0] f_w [3];

	always_comb begin
		if (sb_in.sb.dot_neg)
			ext_w = -$signed({2'b00, sb_in.len}) - $signed({2'b00, sb_in.len0});
		else
			ext_w = $signed({2'b00, sb_in.len}) - $signed({2'b00, sb_in.len0});
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ext_s1 <= sat32(66'(ext_w));
			for (int a = 0; a < 3; a++)
				pv_s1[a] <= $signed(sb_in.sb.v[a]) * $signed(unit[a]);
			u_s1  <= unit;
			dz_s1 <= sb_in.sb.dzero;
			de_s1 <= sb_in.sb.damp_en;
		end
	end

	assign vr_w = 66'(pv_s1[0] >>> 30) + 66'(pv_s1[1] >>> 30) + 66'(pv_s1[2] >>> 30);

	always_ff @(posedge clk) begin
		if (en) begin
			sp_s2 <= $signed(ext_s1) * $signed({1'b0, ks});
			vr_s2 <= de_s1 ? sat32(vr_w) : '0;
			u_s2  <= u_s1;
			dz_s2 <= dz_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			s_s3  <= 48'(sp_s2 >>> 16);
			dp_s3 <= $signed(vr_s2) * $signed({1'b0, kd});
			u_s3  <= u_s2;
			dz_s3 <= dz_s2;
		end
	end

	assign tot_w = 66'(s_s3) + 66'(dp_s3 >>> 16);

	always_ff @(posedge clk) begin
		if (en) begin
			t_s4  <= sat32(tot_w);
			u_s4  <= u_s3;
			dz_s4 <= dz_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int a = 0; a < 3; a++)
				fp_s5[a] <= $signed(u_s4[a]) * $signed(t_s4);
			dz_s5 <= dz_s4;
		end
	end

	always_comb begin
		for (int a = 0; a < 3; a++)
			f_w[a] = sat32(66'(fp_s5[a] >>> 30));
	end

	// output register; a zero separation gives an all-zero beat
	always_ff @(posedge clk) begin
		if (en) begin
			for (int a = 0; a < 3; a++) begin
				f_first[a]  <= dz_s5 ? '0 : f_w[a];
				f_second[a] <= dz_s5 ? '0 : sat32(-66'($signed(f_w[a])));
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_in;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
		end
	end

	assign vld_out = vld_s6;

endmodule
